// File: rtl/core/mrc_pkg.sv
package mrc_pkg;

	localparam int LEN_W      = 5;
	localparam int LIST_DEPTH = 28;
	localparam int POS_W      = 5;
	localparam int MAX_CODES  = 512;
	localparam int RUN_W      = 10;
	localparam int DIG_W      = RUN_W + 1;
	localparam int NCNT_W     = 4;
	localparam int META_W     = 5;
	localparam int CODE_W     = 16;
	localparam int BITS_W     = 5;
	localparam int META_COUNT = 29;
	localparam int TABLE_LEN_SHIFT = 27;

	localparam logic [LEN_W-1:0] TOP_LENGTH = LEN_W'(27);
	localparam logic [RUN_W-1:0] RUN_MAX    = RUN_W'(MAX_CODES);
	localparam logic [RUN_W-1:0] RUN_CAP    = RUN_W'(MAX_CODES - 1);
	localparam logic [META_W-1:0] MTF_BASE  = META_W'(2);

	localparam logic [31:0] META_TABLE [META_COUNT] = '{
		32'h10000000, 32'h1c000000, 32'h12000000, 32'h1d000000, 32'h26000000,
		32'h26800000, 32'h2f000000, 32'h37400000, 32'h37600000, 32'h37800000,
		32'h3fa00000, 32'h3fb00000, 32'h3fc00000, 32'h3fd00000, 32'h47e00000,
		32'h47e80000, 32'h47f00000, 32'h4ff80000, 32'h57fc0000, 32'h5ffe0000,
		32'h67ff0000, 32'h77ff8000, 32'h7fffa000, 32'h7fffb000, 32'h7fffc000,
		32'h7fffd000, 32'h7fffe000, 32'h87fff000, 32'h87fff800
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHG,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [RUN_W-1:0] run;
	} run_ctl_t;

	typedef struct packed {
		logic [NCNT_W-1:0] left;
		logic              digit;
	} run_sts_t;

	function automatic logic [31:0] meta_entry(input logic [META_W-1:0] sym);
		if (sym < META_W'(META_COUNT))
			return META_TABLE[sym];
		return META_TABLE[sym - META_W'(META_COUNT)];
	endfunction

	function automatic logic [BITS_W-1:0] meta_bits(input logic [META_W-1:0] sym);
		logic [31:0] e;
		e = meta_entry(sym);
		return e[31:TABLE_LEN_SHIFT];
	endfunction

	function automatic logic [CODE_W-1:0] meta_word(input logic [META_W-1:0] sym);
		logic [31:0] e;
		logic [TABLE_LEN_SHIFT-1:0] code;
		logic [BITS_W-1:0] sh;
		e    = meta_entry(sym);
		code = e[TABLE_LEN_SHIFT-1:0];
		sh   = BITS_W'(TABLE_LEN_SHIFT) - e[31:TABLE_LEN_SHIFT];
		code = code >> sh;
		return code[CODE_W-1:0];
	endfunction

endpackage

// File: rtl/core/mrc_cell.sv
module mrc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mrc_pkg::LEN_W-1:0] init_val,
	input  logic [mrc_pkg::LEN_W-1:0] key,
	input  logic [mrc_pkg::LEN_W-1:0] left_val,
	input  logic                      found_in,
	input  logic                      is_tail,
	input  logic                      upd,
	input  logic                      clear,
	output logic [mrc_pkg::LEN_W-1:0] val,
	output logic                      found_out,
	output logic                      hit
);
	import mrc_pkg::*;

	logic [LEN_W-1:0] val_q;
	logic             match;

	assign match     = (val_q == key);
	assign found_out = found_in | match;
	assign hit       = !found_in && (match || is_tail);
	assign val       = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= init_val;
		end else if (clear) begin
			val_q <= init_val;
		end else if (upd && !found_in) begin
			val_q <= left_val;
		end
	end

endmodule

// File: rtl/core/mrc_mtf_list.sv
module mrc_mtf_list (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mrc_pkg::LEN_W-1:0] key,
	input  logic [mrc_pkg::LEN_W-1:0] prev,
	input  logic                      upd,
	input  logic                      clear,
	output logic [mrc_pkg::POS_W-1:0] pos
);
	import mrc_pkg::*;

	logic [LIST_DEPTH-1:0] found;
	logic [LIST_DEPTH-1:0] hit;
	logic [LEN_W-1:0]      vals [LIST_DEPTH];

	assign found[0] = 1'b0;
	assign vals[0]  = prev;

	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
		if (k < LIST_DEPTH - 1) begin : g_mid
			mrc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.init_val (LEN_W'(k + 1)),
				.key      (key),
				.left_val (vals[k]),
				.found_in (found[k]),
				.is_tail  (1'b0),
				.upd      (upd),
				.clear    (clear),
				.val      (vals[k+1]),
				.found_out(found[k+1]),
				.hit      (hit[k])
			);
		end else begin : g_tail
			mrc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.init_val (LEN_W'(k + 1)),
				.key      (key),
				.left_val (vals[k]),
				.found_in (found[k]),
				.is_tail  (1'b1),
				.upd      (upd),
				.clear    (clear),
				.val      (),
				.found_out(),
				.hit      (hit[k])
			);
		end
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (hit[i])
				pos = pos | POS_W'(i);
		end
	end

endmodule

// File: rtl/core/mrc_run_digits.sv
module mrc_run_digits (
	input  logic              clk,
	input  logic              arst_n,
	input  mrc_pkg::run_ctl_t ctl,
	output mrc_pkg::run_sts_t sts
);
	import mrc_pkg::*;

	function automatic logic [NCNT_W-1:0] top_bit(input logic [DIG_W-1:0] v);
		logic [NCNT_W-1:0] n;
		n = '0;
		for (int i = 1; i < DIG_W; i++) begin
			if (v[i])
				n = NCNT_W'(i);
		end
		return n;
	endfunction

	logic [DIG_W-1:0]  d_q;
	logic [NCNT_W-1:0] n_q;
	logic [DIG_W-1:0]  load_v;
	logic [NCNT_W-1:0] idx;

	assign load_v    = DIG_W'(ctl.run) + DIG_W'(1);
	assign idx       = n_q - NCNT_W'(1);
	assign sts.left  = n_q;
	assign sts.digit = (n_q != '0) ? d_q[idx] : 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (ctl.load) begin
			n_q <= top_bit(load_v);
		end else if (ctl.step && n_q != '0) begin
			n_q <= idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			d_q <= load_v;
	end

endmodule

// File: rtl/core/mtf_runlength_codelen_encoder.sv
// Move-to-front / run-length coder for Huffman code-length tables.
// Input channel (in_valid/in_ready): one code length per word, last_item on
// the final length of a table. Output channel (out_valid/out_ready): one
// metacode per word with its fixed-table code word and bit count;
// last_of_burst marks the final word caused by one input word.
// An input word is taken while the sequencer is idle; its R results then
// leave one per cycle while the receiver takes them (R is 0..10: run digits,
// then one move-to-front symbol unless the table ends in a run). A length
// that only extends the run gives no result unless last_item is set.
// Results come from the single digit/symbol sequencer feeding the output
// register; the 28-cell move-to-front row searches combinationally and shifts
// when the symbol is emitted. in_ready is high only while the sequencer is
// idle. A stalled receiver holds the output register and the sequencer waits
// on it; nothing is lost. Reset (arst_n low) returns the list to 1..28 and
// clears the previous length and run count; the same state is restored
// in-line, alongside the final result of a word with last_item set.
module mtf_runlength_codelen_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mrc_pkg::LEN_W-1:0]  code_length,
	input  logic                       last_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mrc_pkg::META_W-1:0] meta_symbol,
	output logic [mrc_pkg::CODE_W-1:0] code_word,
	output logic [mrc_pkg::BITS_W-1:0] code_bits,
	output logic                       last_of_burst
);
	import mrc_pkg::*;

	state_t            state_q, state_d;
	logic [LEN_W-1:0]  c_q;
	logic              last_q;
	logic [LEN_W-1:0]  prev_q, prev_d;
	logic [RUN_W-1:0]  run_q, run_d;

	logic              out_valid_q;
	logic [META_W-1:0] sym_q;
	logic [CODE_W-1:0] word_q;
	logic [BITS_W-1:0] bits_q;
	logic              lob_q;

	logic              accept;
	logic              can_emit;
	logic [LEN_W-1:0]  c_in;
	logic              eq_in;
	logic [RUN_W-1:0]  run_inc;
	logic [RUN_W-1:0]  run_cap;

	logic              emit;
	logic [META_W-1:0] emit_sym;
	logic              emit_lob;
	logic              mtf_upd;
	logic              mtf_clear;
	logic [POS_W-1:0]  pos;

	run_ctl_t          rctl;
	run_sts_t          rsts;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign can_emit = !out_valid_q || out_ready;
	assign c_in     = (code_length > TOP_LENGTH) ? TOP_LENGTH : code_length;
	assign eq_in    = (c_in == prev_q);
	assign run_inc  = (run_q < RUN_MAX) ? run_q + RUN_W'(1) : run_q;
	assign run_cap  = (run_q > RUN_CAP) ? RUN_CAP : run_q;

	mrc_mtf_list u_list (
		.clk   (clk),
		.arst_n(arst_n),
		.key   (c_q),
		.prev  (prev_q),
		.upd   (mtf_upd),
		.clear (mtf_clear),
		.pos   (pos)
	);

	mrc_run_digits u_digits (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (rctl),
		.sts   (rsts)
	);

	always_comb begin
		state_d   = state_q;
		prev_d    = prev_q;
		run_d     = run_q;
		rctl      = '0;
		emit      = 1'b0;
		emit_sym  = '0;
		emit_lob  = 1'b0;
		mtf_upd   = 1'b0;
		mtf_clear = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (eq_in) begin
						run_d = run_inc;
						if (last_item) begin
							rctl.load = 1'b1;
							rctl.run  = run_inc;
							state_d   = ST_FLUSH;
						end
					end else begin
						rctl.load = 1'b1;
						rctl.run  = run_cap;
						state_d   = ST_CHG;
					end
				end
			end
			ST_CHG: begin
				if (can_emit) begin
					emit = 1'b1;
					if (rsts.left != '0) begin
						emit_sym  = META_W'(rsts.digit);
						rctl.step = 1'b1;
					end else begin
						emit_sym = META_W'(pos) + MTF_BASE;
						emit_lob = 1'b1;
						mtf_upd  = 1'b1;
						prev_d   = c_q;
						run_d    = '0;
						if (last_q) begin
							mtf_clear = 1'b1;
							prev_d    = '0;
						end
						state_d = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_sym  = META_W'(rsts.digit);
					rctl.step = 1'b1;
					if (rsts.left == NCNT_W'(1)) begin
						emit_lob  = 1'b1;
						mtf_clear = 1'b1;
						prev_d    = '0;
						run_d     = '0;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			prev_q  <= prev_d;
			run_q   <= run_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q    <= c_in;
			last_q <= last_item;
		end
		if (emit) begin
			sym_q  <= emit_sym;
			word_q <= meta_word(emit_sym);
			bits_q <= meta_bits(emit_sym);
			lob_q  <= emit_lob;
		end
	end

	assign out_valid     = out_valid_q;
	assign meta_symbol   = sym_q;
	assign code_word     = word_q;
	assign code_bits     = bits_q;
	assign last_of_burst = lob_q;

endmodule
